### rtl/core/mlp_pkg.sv
// shared types and constants of the message latency preemption controller
// no dependencies; compile first
package mlp_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;

    // event codes on the input channel
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_ARRIVE = 2'd1;
    localparam logic [1:0] OP_REPORT = 2'd2;

    // register indexes on the apb port
    localparam logic [1:0] REG_ENABLE    = 2'd0;
    localparam logic [1:0] REG_WAIT      = 2'd1;
    localparam logic [1:0] REG_MAX_PRE   = 2'd2;
    localparam logic [1:0] REG_STOP      = 2'd3;

    localparam logic [15:0] WAIT_TICKS_RST = 16'd34;
    localparam logic [15:0] MAX_PRE_RST    = 16'd17;
    localparam logic [15:0] STOP_RST       = 16'd17;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAITING,
        PH_CHECKING,
        PH_PREEMPTING
    } phase_t;

    typedef struct packed {
        logic        enable;
        logic [15:0] wait_ticks;
        logic [15:0] max_preempt_ticks;
        logic [15:0] stop_threshold_ticks;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic tick;
        logic arrive;
        logic pop;
        logic eval;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic fire;
        logic pop_hit;
        logic eval_more;
    } stat_t;

endpackage

### rtl/core/mlp_if.sv
// valid/ready channel interfaces for events in and results out
// no dependencies
interface mlp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] processed_count;

    modport source (output valid, output operation, output processed_count, input ready);
    modport sink (input valid, input operation, input processed_count, output ready);
endinterface

interface mlp_out_if;
    logic       valid;
    logic       ready;
    logic       preempting;
    logic [1:0] phase;
    logic [6:0] pending_count;
    logic       dropped;

    modport source (output valid, output preempting, output phase, output pending_count,
                    output dropped, input ready);
    modport sink (input valid, input preempting, input phase, input pending_count,
                  input dropped, output ready);
endinterface

### rtl/core/message_latency_preemption_fsm_core.sv
// top level of the message latency preemption controller: apb registers,
// sequencer and datapath; depends on mlp_pkg, mlp_if, mlp_ctrl, mlp_datapath
// after acceptance: tick, then phase evaluation if the countdown fires; arrival, head read,
// evaluation; report: pops with waits, evaluation; unused op: none; all end in the output load
// one event in flight at a time; the head-entry memory read and the serial pop walk set the rate
// async active-low reset puts the phase at idle, empties the queue, loads register defaults
module message_latency_preemption_fsm_core #(
    parameter int QUEUE_DEPTH = mlp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    mlp_in_if.sink       in_ch,
    mlp_out_if.source    out_ch,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import mlp_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    cmd_t  cmd;
    stat_t stat;
    logic  cfg_wr;

    // apb access phase with zero wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_ENABLE:  cfg_next.enable               = pwdata[0];
                REG_WAIT:    cfg_next.wait_ticks           = pwdata[15:0];
                REG_MAX_PRE: cfg_next.max_preempt_ticks    = pwdata[15:0];
                REG_STOP:    cfg_next.stop_threshold_ticks = pwdata[15:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable               <= 1'b0;
            cfg_reg.wait_ticks           <= WAIT_TICKS_RST;
            cfg_reg.max_preempt_ticks    <= MAX_PRE_RST;
            cfg_reg.stop_threshold_ticks <= STOP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // register readback
    always_comb
    begin
        case (paddr[3:2])
            REG_ENABLE:  prdata = {31'd0, cfg_reg.enable};
            REG_WAIT:    prdata = {16'd0, cfg_reg.wait_ticks};
            REG_MAX_PRE: prdata = {16'd0, cfg_reg.max_preempt_ticks};
            REG_STOP:    prdata = {16'd0, cfg_reg.stop_threshold_ticks};
            default:     prdata = 32'd0;
        endcase
    end

    // sequencer: one transaction at a time, result held in the output register
    mlp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_op     (in_ch.operation),
        .in_ready  (in_ch.ready),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .cmd       (cmd),
        .stat      (stat)
    );

    // phase state, countdown, clock of ticks and the pending queue memory
    mlp_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .cmd               (cmd),
        .stat              (stat),
        .in_count          (in_ch.processed_count),
        .out_preempting    (out_ch.preempting),
        .out_phase         (out_ch.phase),
        .out_pending_count (out_ch.pending_count),
        .out_dropped       (out_ch.dropped)
    );

    // a second event is never taken while one is still being worked
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("input accepted while a transaction is in flight");

    // preempting flag only ever reported together with the preempting phase
    a_pre_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.preempting) |-> (out_ch.phase == PH_PREEMPTING))
        else $error("preempting flag without preempting phase");

    // a loaded result is presented on the next cycle
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_ch.valid)
        else $error("result loaded but not presented");

    // the datapath only steps while no new event can enter
    a_busy_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.tick || cmd.arrive || cmd.pop || cmd.eval) |-> !in_ch.ready)
        else $error("datapath command while input is open");

endmodule

### rtl/core/mlp_ctrl.sv
// sequencing state machine: steps one event through the datapath
// depends on mlp_pkg
module mlp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [1:0]    in_op,
    output logic          in_ready,
    input  logic          out_ready,
    output logic          out_valid,
    output mlp_pkg::cmd_t cmd,
    input  mlp_pkg::stat_t stat
);
    import mlp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_ARRIVE,
        S_ARR_WAIT,
        S_POP,
        S_POP_WAIT,
        S_EVAL,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd          = '0;
        cmd.accept   = accept;
        state_next   = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        OP_TICK:   state_next = S_TICK;
                        OP_ARRIVE: state_next = S_ARRIVE;
                        OP_REPORT: state_next = S_POP;
                        default:   state_next = S_FINISH;
                    endcase
                end
            end
            S_TICK:
            begin
                cmd.tick   = 1'b1;
                state_next = stat.fire ? S_EVAL : S_FINISH;
            end
            S_ARRIVE:
            begin
                cmd.arrive = 1'b1;
                state_next = S_ARR_WAIT;
            end
            // memory read of the head entry catches up
            S_ARR_WAIT: state_next = S_EVAL;
            S_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = stat.pop_hit ? S_POP_WAIT : S_EVAL;
            end
            S_POP_WAIT: state_next = S_POP;
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = stat.eval_more ? S_EVAL : S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/core/mlp_datapath.sv
// phase, countdown, time and pending queue storage with its head read port
// depends on mlp_pkg
module mlp_datapath #(
    parameter int QUEUE_DEPTH = mlp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  mlp_pkg::cfg_t  cfg,
    input  mlp_pkg::cmd_t  cmd,
    output mlp_pkg::stat_t stat,
    input  logic [31:0]    in_count,
    output logic           out_preempting,
    output logic [1:0]     out_phase,
    output logic [6:0]     out_pending_count,
    output logic           out_dropped
);
    import mlp_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    phase_t        phase_reg, phase_next;
    logic [31:0]   rcv_reg, rcv_next;
    logic [31:0]   time_reg, time_next;
    logic [15:0]   cd_reg, cd_next;
    logic          cd_act_reg, cd_act_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [FW-1:0] fill_reg, fill_next;

    logic [31:0]   count_reg;
    logic          drop_reg;
    logic          drop_set;
    logic [63:0]   rd_reg;
    logic [63:0]   entry_mem [QUEUE_DEPTH];
    logic          wr_en;

    logic [31:0]   rd_num;
    logic [31:0]   rd_time;
    logic [31:0]   age;
    logic [31:0]   diff;
    logic          nonempty;

    logic          out_pre_reg;
    logic [1:0]    out_phase_reg;
    logic [6:0]    out_fill_reg;
    logic          out_drop_reg;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // a countdown started at zero fires on the next tick
    function automatic logic [15:0] load_val(input logic [15:0] t);
        return (t == 16'd0) ? 16'd1 : t;
    endfunction

    assign rd_num   = rd_reg[63:32];
    assign rd_time  = rd_reg[31:0];
    assign age      = time_reg - rd_time;
    assign diff     = count_reg - rd_num;
    assign nonempty = (fill_reg != '0);

    always_comb
    begin
        phase_next  = phase_reg;
        rcv_next    = rcv_reg;
        time_next   = time_reg;
        cd_next     = cd_reg;
        cd_act_next = cd_act_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        fill_next   = fill_reg;
        wr_en       = 1'b0;
        drop_set    = 1'b0;

        stat.fire      = cd_act_reg && (cd_reg == 16'd1) && (phase_reg != PH_IDLE);
        stat.pop_hit   = nonempty && !diff[31];
        stat.eval_more = 1'b0;

        if (cmd.tick)
        begin
            time_next = time_reg + 32'd1;
            if (cd_act_reg)
            begin
                cd_next = cd_reg - 16'd1;
                if (cd_reg == 16'd1)
                begin
                    cd_act_next = 1'b0;
                    case (phase_reg)
                        PH_WAITING:    phase_next = PH_CHECKING;
                        PH_PREEMPTING: phase_next = PH_IDLE;
                        default:       phase_next = phase_reg;
                    endcase
                end
            end
        end

        if (cmd.arrive)
        begin
            rcv_next = rcv_reg + 32'd1;
            if (cfg.enable)
            begin
                if (fill_reg != FW'(QUEUE_DEPTH))
                begin
                    wr_en     = 1'b1;
                    tail_next = wrap_inc(tail_reg);
                    fill_next = fill_reg + 1'b1;
                end
                else
                begin
                    drop_set = 1'b1;
                end
            end
        end

        if (cmd.pop && stat.pop_hit)
        begin
            head_next = wrap_inc(head_reg);
            fill_next = fill_reg - 1'b1;
        end

        // one phase transition per cycle; a chain of transitions repeats the evaluation step
        case (phase_reg)
            PH_IDLE:
            begin
                if (cmd.eval && cfg.enable && nonempty)
                begin
                    phase_next  = PH_WAITING;
                    cd_next     = load_val(cfg.wait_ticks);
                    cd_act_next = 1'b1;
                end
            end
            PH_CHECKING:
            begin
                if (nonempty)
                begin
                    if (age < {16'd0, cfg.wait_ticks})
                    begin
                        if (cmd.eval)
                        begin
                            cd_next     = load_val(cfg.wait_ticks - age[15:0]);
                            cd_act_next = 1'b1;
                        end
                    end
                    else
                    begin
                        stat.eval_more = 1'b1;
                        if (cmd.eval)
                        begin
                            phase_next  = PH_PREEMPTING;
                            cd_next     = load_val(cfg.max_preempt_ticks);
                            cd_act_next = 1'b1;
                        end
                    end
                end
            end
            PH_PREEMPTING:
            begin
                if (!nonempty || (age < {16'd0, cfg.stop_threshold_ticks}))
                begin
                    stat.eval_more = 1'b1;
                    if (cmd.eval)
                    begin
                        phase_next  = PH_IDLE;
                        cd_next     = 16'd0;
                        cd_act_next = 1'b0;
                    end
                end
            end
            default: stat.eval_more = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            rcv_reg    <= '0;
            time_reg   <= '0;
            cd_reg     <= '0;
            cd_act_reg <= 1'b0;
            head_reg   <= '0;
            tail_reg   <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            rcv_reg    <= rcv_next;
            time_reg   <= time_next;
            cd_reg     <= cd_next;
            cd_act_reg <= cd_act_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[tail_reg] <= {rcv_next, time_reg};
        end
        rd_reg <= entry_mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            count_reg <= in_count;
            drop_reg  <= 1'b0;
        end
        else if (drop_set)
        begin
            drop_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            out_pre_reg   <= (phase_reg == PH_PREEMPTING) && cfg.enable;
            out_phase_reg <= phase_reg;
            out_fill_reg  <= 7'(fill_reg);
            out_drop_reg  <= drop_reg;
        end
    end

    assign out_preempting    = out_pre_reg;
    assign out_phase         = out_phase_reg;
    assign out_pending_count = out_fill_reg;
    assign out_dropped       = out_drop_reg;

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for message_latency_preemption_fsm_core: directed table, then random events
// every status transaction is checked against the in-bench controller model or a typed table row
// depends on mlp_pkg, mlp_if and the rtl core
module tb;
    import mlp_pkg::*;

    // operation code that the block must ignore, it only reports state back
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int WATCHDOG_LIMIT = 5000;  // quiet cycles before the run is declared hung
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off, fills the block and stalls input
    localparam int SETTLE_CYCLES  = 150;   // worst report: a full queue of 64 pops plus evaluation
    localparam int N_PLAN         = 29;
    localparam int N_PHASES       = 6;

    // one status transaction as the block reports it
    typedef struct packed {
        logic       preempting;
        phase_t     phase;
        logic [6:0] pending;
        logic       dropped;
    } status_t;

    // one row of the directed table: a register write or an event
    typedef struct {
        bit          cfg_row;   // register write instead of an event
        logic [1:0]  code;      // operation, or register index
        logic [31:0] data;      // processed count, or register value
        bit          typed;     // expected status written out in the row
        status_t     want;
    } plan_row_t;

    localparam status_t AT_REST = '{1'b0, PH_IDLE, 7'd0, 1'b0};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mlp_in_if  in_ch ();
    mlp_out_if out_ch ();

    message_latency_preemption_fsm_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // controller model: shadow registers and the block's own state
    // ------------------------------------------------------------------
    cfg_t        shadow_cfg;
    phase_t      ctl_phase;
    logic [31:0] msg_serial;     // number given to the latest arrival
    logic [31:0] now_ticks;      // time in ticks
    logic [15:0] cd_left;        // one-shot countdown
    logic        cd_running;
    logic [31:0] q_serial [QUEUE_DEPTH_DEF];
    logic [31:0] q_stamp  [QUEUE_DEPTH_DEF];
    int unsigned q_head;
    int unsigned q_fill;

    // statuses the block still owes, oldest first
    status_t status_due [$];

    int err_count;
    int n_events;
    int n_status;
    int n_preempt;
    int n_drops;
    int phase_hits [4];

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_req;
    int  hold_left;
    int  quiet_cycles;

    // append one owed status at the tail
    function automatic void owe_status(status_t s);
        status_due = {status_due, s};
    endfunction

    // take the oldest owed status
    function automatic status_t take_status();
        status_t s;
        s = status_due[0];
        status_due.delete(0);
        return s;
    endfunction

    // a zero delay still fires, on the next tick
    function automatic void arm_countdown(logic [31:0] ticks);
        cd_left    = (ticks == 32'd0) ? 16'd1 : ticks[15:0];
        cd_running = 1'b1;
    endfunction

    function automatic logic [31:0] oldest_age();
        return now_ticks - q_stamp[q_head];
    endfunction

    // phase changes chain until the controller rests, as the block repeats its evaluation step
    function automatic void settle_phase();
        logic [31:0] age;
        for (int g = 0; g < 8; g++)
        begin
            case (ctl_phase)
                PH_IDLE:
                begin
                    if (shadow_cfg.enable && q_fill != 0)
                    begin
                        ctl_phase = PH_WAITING;
                        arm_countdown({16'd0, shadow_cfg.wait_ticks});
                    end
                    return;
                end
                PH_WAITING:
                    return;
                PH_CHECKING:
                begin
                    if (q_fill == 0)
                        return;
                    age = oldest_age();
                    if (age < {16'd0, shadow_cfg.wait_ticks})
                    begin
                        // not old enough yet: look again when it will be
                        arm_countdown({16'd0, shadow_cfg.wait_ticks} - age);
                        return;
                    end
                    ctl_phase = PH_PREEMPTING;
                    arm_countdown({16'd0, shadow_cfg.max_preempt_ticks});
                end
                default:
                begin
                    if (q_fill == 0 || oldest_age() < {16'd0, shadow_cfg.stop_threshold_ticks})
                    begin
                        cd_running = 1'b0;
                        cd_left    = 16'd0;
                        ctl_phase  = PH_IDLE;
                    end
                    else
                    begin
                        return;
                    end
                end
            endcase
        end
    endfunction

    function automatic void advance_tick();
        now_ticks++;
        if (!cd_running)
            return;
        cd_left--;
        if (cd_left != 16'd0)
            return;
        cd_running = 1'b0;
        case (ctl_phase)
            PH_WAITING:
            begin
                ctl_phase = PH_CHECKING;
                settle_phase();
            end
            PH_CHECKING:
                settle_phase();
            PH_PREEMPTING:
            begin
                ctl_phase = PH_IDLE;
                settle_phase();
            end
            default:
                ;
        endcase
    endfunction

    // applies one event to the model and returns the status it should produce
    function automatic status_t next_status(logic [1:0] op, logic [31:0] count);
        status_t     s;
        int unsigned slot;
        s = AT_REST;
        case (op)
            OP_TICK:
                advance_tick();
            OP_ARRIVE:
            begin
                msg_serial++;
                if (shadow_cfg.enable)
                begin
                    if (q_fill < QUEUE_DEPTH_DEF)
                    begin
                        slot           = (q_head + q_fill) % QUEUE_DEPTH_DEF;
                        q_serial[slot] = msg_serial;
                        q_stamp[slot]  = now_ticks;
                        q_fill++;
                    end
                    else
                    begin
                        s.dropped = 1'b1;
                    end
                end
                settle_phase();
            end
            OP_REPORT:
            begin
                // serial compare: the entry is done when count is at or past its number
                while (q_fill != 0 && (count - q_serial[q_head]) < 32'h8000_0000)
                begin
                    q_head = (q_head + 1) % QUEUE_DEPTH_DEF;
                    q_fill--;
                end
                settle_phase();
            end
            default:
                ;
        endcase
        s.preempting = (ctl_phase == PH_PREEMPTING) && shadow_cfg.enable;
        s.phase      = ctl_phase;
        s.pending    = 7'(q_fill);
        return s;
    endfunction

    function automatic logic [31:0] reg_mask(logic [1:0] idx);
        return (idx == REG_ENABLE) ? 32'h1 : 32'hFFFF;
    endfunction

    function automatic logic [31:0] shadow_reg(logic [1:0] idx);
        case (idx)
            REG_ENABLE:  return {31'd0, shadow_cfg.enable};
            REG_WAIT:    return {16'd0, shadow_cfg.wait_ticks};
            REG_MAX_PRE: return {16'd0, shadow_cfg.max_preempt_ticks};
            default:     return {16'd0, shadow_cfg.stop_threshold_ticks};
        endcase
    endfunction

    function automatic void check_readback(logic [1:0] idx, logic [31:0] rd);
        if ((rd & reg_mask(idx)) != shadow_reg(idx))
        begin
            $error("register %0d readback: expected %0d, got %0d", idx, shadow_reg(idx),
                   rd & reg_mask(idx));
            err_count++;
        end
    endfunction

    function automatic void report_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // apb port: setup cycle, access cycle, then an idle cycle
    // ------------------------------------------------------------------
    task automatic apb_xfer(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // write a register, mirror it in the model and read it back
    task automatic set_register(logic [1:0] idx, logic [31:0] value);
        logic [31:0] rd;
        apb_xfer(1'b1, idx, value, rd);
        case (idx)
            REG_ENABLE:  shadow_cfg.enable               = value[0];
            REG_WAIT:    shadow_cfg.wait_ticks           = value[15:0];
            REG_MAX_PRE: shadow_cfg.max_preempt_ticks    = value[15:0];
            default:     shadow_cfg.stop_threshold_ticks = value[15:0];
        endcase
        apb_xfer(1'b0, idx, 32'd0, rd);
        check_readback(idx, rd);
    endtask

    // ------------------------------------------------------------------
    // event side: enter and leave at a falling edge
    // ------------------------------------------------------------------
    task automatic send_event(logic [1:0] op, logic [31:0] count, bit typed, status_t want);
        status_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.operation       <= op;
        in_ch.processed_count <= count;
        do
            @(posedge clk);
        while (!in_ch.ready);
        // accepted at this edge: the model moves with the block
        predicted = next_status(op, count);
        owe_status(typed ? want : predicted);
        n_events++;
        @(negedge clk);
    endtask

    // stop offering and wait until every owed status has arrived
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // mostly ticks and arrivals with reports close to the arrival count, so queued
    // entries age into preemption and get popped in bunches
    task automatic send_random(int n);
        int          r;
        logic [1:0]  op;
        logic [31:0] count;
        for (int i = 0; i < n; i++)
        begin
            r     = $urandom_range(0, 99);
            count = $urandom;
            if (r < 48)
                op = OP_TICK;
            else if (r < 74)
                op = OP_ARRIVE;
            else if (r < 96)
            begin
                op = OP_REPORT;
                case ($urandom_range(0, 9))
                    0:       ;  // raw draw, usually far from any queued number
                    1:       count = msg_serial + $urandom_range(1, 3);
                    default: count = msg_serial - $urandom_range(0, 6);
                endcase
            end
            else
                op = OP_UNUSED;
            send_event(op, count, 1'b0, AT_REST);
        end
    endtask

    // ------------------------------------------------------------------
    // directed table: idle behavior after reset, extremes of the count,
    // serial compare across the half range, unused operation, enable cleared
    // ------------------------------------------------------------------
    plan_row_t directed_plan [N_PLAN] = '{
        // enable is low after reset: nothing is queued, phase stays idle
        '{1'b0, OP_TICK,     32'h0000_0000, 1'b1, AT_REST},
        '{1'b0, OP_ARRIVE,   32'hFFFF_FFFF, 1'b1, AT_REST},
        '{1'b0, OP_REPORT,   32'hFFFF_FFFF, 1'b1, AT_REST},
        '{1'b0, OP_UNUSED,   32'h5A5A_5A5A, 1'b1, AT_REST},
        // short delays, no stop threshold
        '{1'b1, REG_ENABLE,  32'd1,         1'b0, AT_REST},
        '{1'b1, REG_WAIT,    32'd2,         1'b0, AT_REST},
        '{1'b1, REG_MAX_PRE, 32'd1,         1'b0, AT_REST},
        '{1'b1, REG_STOP,    32'd0,         1'b0, AT_REST},
        // first queued arrival moves idle straight to waiting
        '{1'b0, OP_ARRIVE,   32'h0000_0000, 1'b1, '{1'b0, PH_WAITING, 7'd1, 1'b0}},
        '{1'b0, OP_TICK,     32'h0000_0000, 1'b0, AT_REST},
        '{1'b0, OP_TICK,     32'h0000_0000, 1'b0, AT_REST},
        '{1'b0, OP_ARRIVE,   32'h0000_0000, 1'b0, AT_REST},
        '{1'b0, OP_TICK,     32'h0000_0000, 1'b0, AT_REST},
        // count behind the queued numbers pops nothing, half a range ahead pops all
        '{1'b0, OP_REPORT,   32'h0000_0000, 1'b0, AT_REST},
        '{1'b0, OP_REPORT,   32'h8000_0001, 1'b0, AT_REST},
        // countdown fires into checking with an empty queue
        '{1'b0, OP_TICK,     32'h0000_0000, 1'b0, AT_REST},
        '{1'b0, OP_TICK,     32'h0000_0000, 1'b0, AT_REST},
        '{1'b0, OP_ARRIVE,   32'hA5A5_A5A5, 1'b0, AT_REST},
        // maximal stop threshold drops preemption at once
        '{1'b1, REG_STOP,    32'h0000_FFFF, 1'b0, AT_REST},
        '{1'b1, REG_WAIT,    32'd1,         1'b0, AT_REST},
        '{1'b1, REG_MAX_PRE, 32'h0000_FFFF, 1'b0, AT_REST},
        '{1'b0, OP_TICK,     32'h0000_0000, 1'b0, AT_REST},
        '{1'b0, OP_TICK,     32'h0000_0000, 1'b0, AT_REST},
        '{1'b0, OP_TICK,     32'h0000_0000, 1'b0, AT_REST},
        '{1'b0, OP_REPORT,   32'h0000_0004, 1'b0, AT_REST},
        // enable cleared: arrivals are numbered but not queued
        '{1'b1, REG_ENABLE,  32'd0,         1'b0, AT_REST},
        '{1'b0, OP_ARRIVE,   32'hFFFF_FFFF, 1'b0, AT_REST},
        '{1'b0, OP_UNUSED,   32'h0000_0000, 1'b0, AT_REST},
        '{1'b0, OP_TICK,     32'h0000_0000, 1'b0, AT_REST}
    };

    // register settings of the random phases; the long-delay extremes come last so a
    // countdown of 65535 ticks does not freeze the phases after it
    cfg_t phase_cfg [N_PHASES] = '{
        '{1'b1, 16'd3,     16'd4,     16'd2},
        '{1'b1, 16'd1,     16'd1,     16'd0},
        '{1'b0, 16'd5,     16'd2,     16'd1},
        '{1'b1, 16'd8,     16'd6,     16'd4},
        '{1'b1, 16'd4,     16'hFFFF,  16'd3},
        '{1'b1, 16'hFFFF,  16'd1,     16'hFFFF}
    };

    // ------------------------------------------------------------------
    // result side: ready changes at the falling edge, with an optional long hold-off
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req <= 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // compare each status transaction with the oldest owed one
    always @(posedge clk)
    begin
        status_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (status_due.size() == 0)
            begin
                $error("status transaction with nothing owed: phase %0d, pending %0d",
                       out_ch.phase, out_ch.pending_count);
                err_count++;
            end
            else
            begin
                want = take_status();
                report_field("preempting", want.preempting, out_ch.preempting);
                report_field("phase", want.phase, out_ch.phase);
                report_field("pending_count", want.pending, out_ch.pending_count);
                report_field("dropped", want.dropped, out_ch.dropped);
            end
            n_status++;
            if (out_ch.preempting)
                n_preempt++;
            if (out_ch.dropped)
                n_drops++;
            phase_hits[out_ch.phase]++;
        end
    end

    // watchdog: any handshake or register access counts as progress
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("message_latency_preemption_fsm_core regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [31:0] rd;
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        in_ch.valid           = 1'b0;
        in_ch.operation       = OP_TICK;
        in_ch.processed_count = '0;
        out_ch.ready          = 1'b0;
        hold_req              = 1'b0;
        hold_left             = 0;
        quiet_cycles          = 0;
        err_count             = 0;
        n_events              = 0;
        n_status              = 0;
        n_preempt             = 0;
        n_drops               = 0;
        phase_hits            = '{0, 0, 0, 0};
        send_idle_pct         = 31;
        recv_idle_pct         = 61;

        // model state after reset
        shadow_cfg = '{1'b0, WAIT_TICKS_RST, MAX_PRE_RST, STOP_RST};
        ctl_phase  = PH_IDLE;
        msg_serial = '0;
        now_ticks  = '0;
        cd_left    = '0;
        cd_running = 1'b0;
        q_head     = 0;
        q_fill     = 0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // register defaults
        for (int i = 0; i < 4; i++)
        begin
            apb_xfer(1'b0, 2'(i), 32'd0, rd);
            check_readback(2'(i), rd);
        end

        // directed table, sender idles 31 percent and receiver 61 percent
        foreach (directed_plan[i])
        begin
            if (directed_plan[i].cfg_row)
            begin
                drain();
                set_register(directed_plan[i].code, directed_plan[i].data);
            end
            else
            begin
                send_event(directed_plan[i].code, directed_plan[i].data,
                           directed_plan[i].typed, directed_plan[i].want);
            end
        end

        // random phases: idling swaps after two phases, then stops altogether
        for (int p = 0; p < N_PHASES; p++)
        begin
            drain();
            send_idle_pct = (p < 2) ? 31 : (p < 4) ? 61 : 0;
            recv_idle_pct = (p < 2) ? 61 : (p < 4) ? 31 : 0;
            set_register(REG_ENABLE,  {31'd0, phase_cfg[p].enable});
            set_register(REG_WAIT,    {16'd0, phase_cfg[p].wait_ticks});
            set_register(REG_MAX_PRE, {16'd0, phase_cfg[p].max_preempt_ticks});
            set_register(REG_STOP,    {16'd0, phase_cfg[p].stop_threshold_ticks});
            if (p == 1)
            begin
                // flood of arrivals overfills the queue; later reports pop long runs
                for (int k = 0; k < 70; k++)
                    send_event(OP_ARRIVE, $urandom, 1'b0, AT_REST);
            end
            if (p == 4)
                hold_req <= 1'b1;  // receiver stalls while events keep coming
            send_random(35);
            if (p == 3)
                drain();  // sender pauses until the block has answered everything
            send_random(35);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d events and %0d status transactions, %0d preempting, %0d dropped",
                 n_events, n_status, n_preempt, n_drops);
        $display("statuses per phase idle/waiting/checking/preempting: %0d/%0d/%0d/%0d",
                 phase_hits[0], phase_hits[1], phase_hits[2], phase_hits[3]);
        if (err_count == 0)
            $display("message_latency_preemption_fsm_core regression: pass");
        else
            $display("message_latency_preemption_fsm_core regression: fail");
        $finish;
    end

endmodule

### filelist.f
rtl/core/mlp_pkg.sv
rtl/core/mlp_if.sv
rtl/core/mlp_ctrl.sv
rtl/core/mlp_datapath.sv
rtl/core/message_latency_preemption_fsm_core.sv
tb/tb.sv
